>>> rtl/core/cfe_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame encoder.
`timescale 1ns / 1ps

package cfe_pkg;

  localparam logic [7:0]  SYNC_A     = 8'hAA;
  localparam logic [7:0]  SYNC_B     = 8'h55;
  localparam logic [7:0]  DATA_CMD   = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] SEED_RESET = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  // Serializer step numbers
  localparam logic [3:0] STEP_FIRST     = 4'd0;
  localparam logic [3:0] STEP_HDR_LAST  = 4'd6;
  localparam logic [3:0] STEP_HDR_CRCLO = 4'd7;
  localparam logic [3:0] STEP_HDR_CRCHI = 4'd8;
  localparam logic [3:0] STEP_DAT_CRCLO = 4'd1;
  localparam logic [3:0] STEP_DAT_CRCHI = 4'd2;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_HDR  = 2'd1,
    OP_DATA = 2'd2
  } opcode_e;

  typedef enum logic {
    JOB_HDR  = 1'b0,
    JOB_DATA = 1'b1
  } job_kind_e;

  // One unit of work for the serializer; a payload byte travels in opt[7:0]
  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  cmd;
    logic [15:0] opt;
    logic        tail;   // append the CRC after this job's bytes
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/cfe_in_if.sv
// Input item channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps

interface cfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  cmd_code;
  logic [15:0] opt_word;
  logic [7:0]  data_byte;

  modport source (output valid, output opcode, output cmd_code, output opt_word,
                  output data_byte, input ready);
  modport sink (input valid, input opcode, input cmd_code, input opt_word,
                input data_byte, output ready);
endinterface

>>> rtl/core/cfe_out_if.sv
// Output byte channel: valid/ready handshake with the serialized byte.
`timescale 1ns / 1ps

interface cfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/core/cfe_front.sv
// Front end: accepts items, tracks the open data frame and issues serializer jobs.
`timescale 1ns / 1ps

module cfe_front import cfe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfe_in_if.sink in_i,
  input  logic   full_i,
  output push_t  push_o
);

  logic [15:0] remain_q, remain_d;
  logic        accept;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;

  always_comb begin
    remain_d          = remain_q;
    push_o.valid      = 1'b0;
    push_o.job.kind   = JOB_HDR;
    push_o.job.cmd    = in_i.cmd_code;
    push_o.job.opt    = in_i.opt_word;
    push_o.job.tail   = 1'b1;
    if (accept) begin
      case (in_i.opcode)
        OP_CMD: begin
          push_o.valid = 1'b1;
          remain_d     = '0;
        end
        OP_HDR: begin
          push_o.valid    = 1'b1;
          push_o.job.cmd  = DATA_CMD;
          push_o.job.tail = (in_i.opt_word == '0);
          remain_d        = in_i.opt_word;
        end
        OP_DATA: begin
          // drop payload when no frame is open
          if (remain_q != '0) begin
            push_o.valid    = 1'b1;
            push_o.job.kind = JOB_DATA;
            push_o.job.opt  = {8'h00, in_i.data_byte};
            push_o.job.tail = (remain_q == 16'd1);
            remain_d        = remain_q - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else begin
      remain_q <= remain_d;
    end
  end

endmodule

>>> rtl/core/cfe_queue.sv
// Job queue between the front end and the serializer.
`timescale 1ns / 1ps

module cfe_queue import cfe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output job_t  head_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  job_t          slots_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/cfe_back.sv
// Serializer: emits one frame byte per cycle from queued jobs while output is ready; keeps the CRC.
`timescale 1ns / 1ps

module cfe_back import cfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] seed_i,
  input  logic        empty_i,
  input  job_t        head_i,
  output logic        pop_o,
  cfe_out_if.source   out_o
);

  logic [3:0]  step_q, step_d, step_end;
  logic [15:0] crc_q, crc_d, crc_in;
  logic        out_valid_q, emit, crc_use;
  logic [7:0]  out_byte_q, byte_d;
  logic        out_last_q;

  assign emit  = ~empty_i & (~out_valid_q | out_o.ready);
  assign pop_o = emit & (step_q == step_end);

  always_comb begin
    byte_d  = crc_q[15:8];
    crc_use = 1'b0;
    crc_in  = crc_q;
    if (head_i.kind == JOB_HDR) begin
      step_end = head_i.tail ? STEP_HDR_CRCHI : STEP_HDR_LAST;
      if (step_q == STEP_FIRST) begin
        crc_in = seed_i;
      end
      crc_use = (step_q <= STEP_HDR_LAST);
      case (step_q)
        4'd0:           byte_d = SYNC_A;
        4'd1:           byte_d = SYNC_B;
        4'd2:           byte_d = head_i.cmd;
        4'd3:           byte_d = head_i.opt[7:0];
        4'd4:           byte_d = head_i.opt[15:8];
        4'd5:           byte_d = ~head_i.opt[7:0];
        4'd6:           byte_d = ~head_i.opt[15:8];
        STEP_HDR_CRCLO: byte_d = crc_q[7:0];
        default:        byte_d = crc_q[15:8];
      endcase
    end else begin
      step_end = head_i.tail ? STEP_DAT_CRCHI : STEP_FIRST;
      crc_use  = (step_q == STEP_FIRST);
      case (step_q)
        STEP_FIRST:     byte_d = head_i.opt[7:0];
        STEP_DAT_CRCLO: byte_d = crc_q[7:0];
        default:        byte_d = crc_q[15:8];
      endcase
    end
    crc_d  = (emit && crc_use) ? crc_byte(crc_in, byte_d) : crc_q;
    step_d = emit ? ((step_q == step_end) ? STEP_FIRST : step_q + 4'd1) : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FIRST;
      crc_q       <= SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      crc_q  <= crc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_d;
      out_last_q <= pop_o;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;

endmodule

>>> rtl/core/crc16_command_frame_encoder.sv
// An item's first byte passes the job queue and output register before it is offered.
// The serializer sends one byte per cycle while jobs wait and the output is ready. A
// command frame is nine bytes, a data header seven (nine at size zero), a payload byte
// one, the last three. The queue lets input flow while the serializer works or stalls,
// until full. Reset clears queue, open frame and output; the CRC seed returns to 0xFFFF.
`timescale 1ns / 1ps

module crc16_command_frame_encoder import cfe_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfe_in_if.sink      in_i,
  cfe_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] seed_q;
  push_t       push;
  job_t        head;
  logic        full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  cfe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  cfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  cfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seed_i  (seed_q),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
